// ===== sv/hgsd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hgsd_pkg
// Shared types and constants of the height-grid local step detector.
// ----------------------------------------------------------------------------
package hgsd_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int HEIGHT_BITS    = 16;
    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int LINE_BITS      = 11;
    localparam int ROW_BITS       = 11;
    localparam int DIFF_BITS      = 16;
    localparam int CMP_BITS       = LINE_BITS + COL_BITS;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CELL_BITS      = HEIGHT_BITS + 2;
    localparam int OUTQ_DEPTH     = 16;
    localparam int OUTQ_PTR_BITS  = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_BITS  = $clog2(OUTQ_DEPTH + 1);
    localparam int PIPE_STAGES    = 4;
    localparam int RSV_BITS       = $clog2(OUTQ_DEPTH + 2 * PIPE_STAGES + 1);

    localparam logic [LINE_BITS-1:0] LINE_WIDTH_RESET = LINE_BITS'(1024);
    localparam logic [ROW_BITS-1:0]  FRAME_ROWS_RESET = ROW_BITS'(1024);
    localparam logic [DIFF_BITS-1:0] MAX_DIFF_RESET   = DIFF_BITS'(1000);
    localparam logic [DIFF_BITS-1:0] MIN_DIFF_RESET   = DIFF_BITS'(100);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LINE_WIDTH = 2'd0,
        CFG_FRAME_ROWS = 2'd1,
        CFG_MAX_DIFF   = 2'd2,
        CFG_MIN_DIFF   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [LINE_BITS-1:0] line_width;
        logic [ROW_BITS-1:0]  frame_rows;
        logic [DIFF_BITS-1:0] max_diff;
        logic [DIFF_BITS-1:0] min_diff;
    } cfg_t;

    typedef struct packed {
        logic signed [HEIGHT_BITS-1:0] h;
        logic                          p;
        logic                          rc;
    } cell_t;

    // Result A is the centre one column back, result B the last cell of a row.
    typedef struct packed {
        logic res_a;
        logic res_b;
        logic left_a;
        logic left_b;
        logic top_ok;
        logic bottom_ok;
    } emit_flags_t;

    typedef struct packed {
        logic                   valid;
        emit_flags_t            flags;
        cell_t [2:0][2:0]       cells;
    } win_stage_t;

    typedef struct packed {
        logic [DIFF_BITS-1:0] step_size;
        logic                 marked;
        logic                 center_present;
        logic                 apply;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic    valid;
        logic    a_en;
        result_t a;
        logic    b_en;
        result_t b;
    } res_pair_t;

    function automatic logic [DIFF_BITS-1:0] abs_diff(
        input logic signed [HEIGHT_BITS-1:0] x,
        input logic signed [HEIGHT_BITS-1:0] y
    );
        logic signed [HEIGHT_BITS:0] d;
        logic signed [HEIGHT_BITS:0] n;
        d = {x[HEIGHT_BITS-1], x} - {y[HEIGHT_BITS-1], y};
        n = -d;
        return d[HEIGHT_BITS] ? DIFF_BITS'(n) : DIFF_BITS'(d);
    endfunction

endpackage
`default_nettype wire

// ===== sv/hgsd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hgsd_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module hgsd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/hgsd_window.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hgsd_window
// Raster counters, the two line buffers and the 3x3 window register.
// ----------------------------------------------------------------------------
module hgsd_window (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hgsd_pkg::cfg_t      cfg,
    input  wire logic                in_accept,
    input  wire hgsd_pkg::cell_t     in_cell,
    output      logic                s1_valid,
    output      hgsd_pkg::win_stage_t win
);
    import hgsd_pkg::*;

    logic [COL_BITS-1:0] col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [CMP_BITS-1:0] w_lim;
    logic [CMP_BITS-1:0] w_last;
    logic [ROW_BITS-1:0] f_lim;
    logic                is_last;
    logic                pad;
    emit_flags_t         flags_now;

    logic                s1_valid_reg;
    cell_t               s1_cell_reg;
    logic [COL_BITS-1:0] s1_col_reg;
    emit_flags_t         s1_flags_reg;

    logic                byp_reg;
    cell_t               byp_u_reg;
    cell_t               byp_m_reg;
    logic [CELL_BITS-1:0] u_rdata, m_rdata;
    cell_t               u_s1, m_s1;

    win_stage_t          win_reg, win_next;

    always_comb
    begin
        if (cfg.line_width == '0)
        begin
            w_lim = CMP_BITS'(1);
        end
        else if (CMP_BITS'(cfg.line_width) > CMP_BITS'(MAX_WIDTH))
        begin
            w_lim = CMP_BITS'(MAX_WIDTH);
        end
        else
        begin
            w_lim = CMP_BITS'(cfg.line_width);
        end
        w_last  = w_lim - CMP_BITS'(1);
        f_lim   = (cfg.frame_rows == '0) ? ROW_BITS'(1) : cfg.frame_rows;
        is_last = CMP_BITS'(col_reg) >= w_last;
        pad     = row_reg >= f_lim;

        flags_now.res_a     = (row_reg != '0) && (col_reg != '0);
        flags_now.res_b     = (row_reg != '0) && is_last;
        flags_now.left_a    = col_reg >= COL_BITS'(2);
        flags_now.left_b    = col_reg != '0;
        flags_now.top_ok    = row_reg >= ROW_BITS'(2);
        flags_now.bottom_ok = !pad;

        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (is_last)
            begin
                col_next = '0;
                row_next = pad ? '0 : row_reg + ROW_BITS'(1);
            end
            else
            begin
                col_next = col_reg + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= in_accept;
            byp_reg      <= in_accept && s1_valid_reg && (s1_col_reg == col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cell_reg  <= in_cell;
            s1_col_reg   <= col_reg;
            s1_flags_reg <= flags_now;
        end
        byp_u_reg <= m_s1;
        byp_m_reg <= s1_cell_reg;
    end

    // The previous transaction writes the entry that this one reads in the
    // same cycle only when the row is a single cell wide.
    assign u_s1 = byp_reg ? byp_u_reg : cell_t'(u_rdata);
    assign m_s1 = byp_reg ? byp_m_reg : cell_t'(m_rdata);

    hgsd_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (m_s1),
        .re    (in_accept),
        .raddr (col_reg),
        .rdata (u_rdata)
    );

    hgsd_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_cell_reg),
        .re    (in_accept),
        .raddr (col_reg),
        .rdata (m_rdata)
    );

    always_comb
    begin
        win_next       = win_reg;
        win_next.valid = s1_valid_reg;
        if (s1_valid_reg)
        begin
            win_next.flags    = s1_flags_reg;
            win_next.cells[0] = win_reg.cells[1];
            win_next.cells[1] = win_reg.cells[2];
            win_next.cells[2][0] = u_s1;
            win_next.cells[2][1] = m_s1;
            win_next.cells[2][2] = s1_cell_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign win      = win_reg;

endmodule
`default_nettype wire

// ===== sv/hgsd_diff.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hgsd_diff
// Neighbour differences, largest-difference search, clamp and threshold.
// ----------------------------------------------------------------------------
module hgsd_diff (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire hgsd_pkg::cfg_t       cfg,
    input  wire hgsd_pkg::win_stage_t win,
    output      logic                 s3_valid,
    output      hgsd_pkg::res_pair_t  pair
);
    import hgsd_pkg::*;

    logic [DIFF_BITS-1:0] da_next [9];
    logic [DIFF_BITS-1:0] db_next [6];
    logic [DIFF_BITS-1:0] da_reg  [9];
    logic [DIFF_BITS-1:0] db_reg  [6];
    cell_t                ca_reg, cb_reg;
    logic                 s3_a_reg, s3_b_reg;
    logic                 s3_valid_reg;

    logic [DIFF_BITS-1:0] best_a_next, best_b_next;
    logic [DIFF_BITS-1:0] best_a_reg, best_b_reg;
    logic                 pa_reg, rca_reg, pb_reg, rcb_reg;
    logic                 s4_a_reg, s4_b_reg;
    logic                 s4_valid_reg;

    logic [DIFF_BITS-1:0] clamp_a, clamp_b;
    logic                 mark_a, mark_b;

    always_comb
    begin
        logic row_ok;
        logic inc;
        for (int col = 0; col < 3; col++)
        begin
            for (int row = 0; row < 3; row++)
            begin
                row_ok = (row == 0) ? win.flags.top_ok :
                         (row == 2) ? win.flags.bottom_ok : 1'b1;
                inc = win.cells[col][row].p && row_ok &&
                      ((col != 0) || win.flags.left_a);
                da_next[col*3+row] = inc ?
                    abs_diff(win.cells[col][row].h, win.cells[1][1].h) : '0;
                if (col != 0)
                begin
                    inc = win.cells[col][row].p && row_ok &&
                          ((col != 1) || win.flags.left_b);
                    db_next[(col-1)*3+row] = inc ?
                        abs_diff(win.cells[col][row].h, win.cells[2][1].h) : '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (win.valid)
        begin
            da_reg   <= da_next;
            db_reg   <= db_next;
            ca_reg   <= win.cells[1][1];
            cb_reg   <= win.cells[2][1];
            s3_a_reg <= win.flags.res_a;
            s3_b_reg <= win.flags.res_b;
        end
    end

    always_comb
    begin
        best_a_next = da_reg[0];
        for (int k = 1; k < 9; k++)
        begin
            if (da_reg[k] > best_a_next)
            begin
                best_a_next = da_reg[k];
            end
        end
        best_b_next = db_reg[0];
        for (int k = 1; k < 6; k++)
        begin
            if (db_reg[k] > best_b_next)
            begin
                best_b_next = db_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            best_a_reg <= best_a_next;
            best_b_reg <= best_b_next;
            pa_reg     <= ca_reg.p;
            rca_reg    <= ca_reg.rc;
            pb_reg     <= cb_reg.p;
            rcb_reg    <= cb_reg.rc;
            s4_a_reg   <= s3_a_reg;
            s4_b_reg   <= s3_b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= win.valid;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_comb
    begin
        clamp_a = (best_a_reg > cfg.max_diff) ? cfg.max_diff : best_a_reg;
        clamp_b = (best_b_reg > cfg.max_diff) ? cfg.max_diff : best_b_reg;
        mark_a  = pa_reg && (clamp_a > cfg.min_diff);
        mark_b  = pb_reg && (clamp_b > cfg.min_diff);

        pair.valid              = s4_valid_reg;
        pair.a_en               = s4_a_reg;
        pair.a.step_size        = mark_a ? clamp_a : '0;
        pair.a.marked           = mark_a;
        pair.a.center_present   = pa_reg;
        pair.a.apply            = rca_reg;
        pair.a.last             = !s4_b_reg;
        pair.b_en               = s4_b_reg;
        pair.b.step_size        = mark_b ? clamp_b : '0;
        pair.b.marked           = mark_b;
        pair.b.center_present   = pb_reg;
        pair.b.apply            = rcb_reg;
        pair.b.last             = 1'b1;
    end

    assign s3_valid = s3_valid_reg;

endmodule
`default_nettype wire

// ===== sv/hgsd_outq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hgsd_outq
// Result queue that takes up to two results a cycle and drives the master side.
// ----------------------------------------------------------------------------
module hgsd_outq (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire hgsd_pkg::res_pair_t                 pair,
    output      logic [hgsd_pkg::OUTQ_CNT_BITS-1:0]  count,
    output      logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output      logic [15:0]                         m_axis_tdata,  // step_size
    output      logic [2:0]                          m_axis_tuser,  // marked, center_present, apply
    output      logic                                m_axis_tlast
);
    import hgsd_pkg::*;

    result_t                  q_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_BITS-1:0] wp_reg, wp_next;
    logic [OUTQ_PTR_BITS-1:0] rp_reg, rp_next;
    logic [OUTQ_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                     push_a, push_b, pop;
    logic [OUTQ_PTR_BITS-1:0] b_ptr;
    result_t                  head;

    assign push_a = pair.valid && pair.a_en;
    assign push_b = pair.valid && pair.b_en;
    assign pop    = m_axis_tvalid && m_axis_tready;
    assign b_ptr  = push_a ? wp_reg + OUTQ_PTR_BITS'(1) : wp_reg;

    always_comb
    begin
        wp_next  = wp_reg + OUTQ_PTR_BITS'(push_a) + OUTQ_PTR_BITS'(push_b);
        rp_next  = rp_reg + OUTQ_PTR_BITS'(pop);
        cnt_next = cnt_reg + OUTQ_CNT_BITS'(push_a) + OUTQ_CNT_BITS'(push_b)
                   - OUTQ_CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            q_mem[wp_reg] <= pair.a;
        end
        if (push_b)
        begin
            q_mem[b_ptr] <= pair.b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    assign head          = q_mem[rp_reg];
    assign m_axis_tvalid = cnt_reg != '0;
    assign m_axis_tdata  = head.step_size;
    assign m_axis_tuser  = {head.apply, head.center_present, head.marked};
    assign m_axis_tlast  = head.last;
    assign count         = cnt_reg;

endmodule
`default_nettype wire

// ===== sv/height_grid_local_step_detector_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// height_grid_local_step_detector_unit
// Streaming 3x3 largest-height-difference filter over a raster height grid.
// ----------------------------------------------------------------------------
// The block accepts one cell per clock cycle and keeps that rate indefinitely
// while the result side is ready. Each cell passes through a line-buffer read
// stage, the window register, a difference stage and a search stage before
// its results enter the queue; in the raster a result is one row and, but for a
// row's last cell, one cell behind the input; the last cell of each row after the
// first gives two results that enter the queue together, unless the row is one
// cell wide. The line buffers are two single-port-write RAMs of one entry per
// column, read and written back once per cell. Results wait in a sixteen-entry
// queue; the input side is held off only while that queue, counting the room kept
// for cells still in flight, is nearly full. No clearing pass is needed after reset.
module height_grid_local_step_detector_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output      logic                                 s_axis_tready,
    input  wire logic [15:0]                          s_axis_tdata,  // height
    input  wire logic [1:0]                           s_axis_tuser,  // present, recompute
    output      logic                                 m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output      logic [15:0]                          m_axis_tdata,  // step_size
    output      logic [2:0]                           m_axis_tuser,  // marked, center_present, apply
    output      logic                                 m_axis_tlast,
    input  wire logic                                 cfg_we,
    input  wire logic [hgsd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [hgsd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
    import hgsd_pkg::*;

    cfg_t                     cfg_reg, cfg_next;
    logic                     in_accept;
    cell_t                    in_cell;
    logic                     s1_valid;
    logic                     s3_valid;
    win_stage_t               win;
    res_pair_t                pair;
    logic [OUTQ_CNT_BITS-1:0] q_count;
    logic [RSV_BITS-1:0]      reserved;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_LINE_WIDTH: cfg_next.line_width = cfg_wdata[LINE_BITS-1:0];
                CFG_FRAME_ROWS: cfg_next.frame_rows = cfg_wdata[ROW_BITS-1:0];
                CFG_MAX_DIFF:   cfg_next.max_diff   = cfg_wdata[DIFF_BITS-1:0];
                CFG_MIN_DIFF:   cfg_next.min_diff   = cfg_wdata[DIFF_BITS-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_width <= LINE_WIDTH_RESET;
            cfg_reg.frame_rows <= FRAME_ROWS_RESET;
            cfg_reg.max_diff   <= MAX_DIFF_RESET;
            cfg_reg.min_diff   <= MIN_DIFF_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Every cell in flight keeps room for two results in the queue.
    assign reserved = RSV_BITS'(q_count)
                    + RSV_BITS'(2) * (RSV_BITS'(s1_valid) + RSV_BITS'(win.valid)
                                    + RSV_BITS'(s3_valid) + RSV_BITS'(pair.valid));
    assign s_axis_tready = reserved <= RSV_BITS'(OUTQ_DEPTH - 2);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign in_cell.h  = s_axis_tdata;
    assign in_cell.p  = s_axis_tuser[0];
    assign in_cell.rc = s_axis_tuser[1];

    hgsd_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_accept (in_accept),
        .in_cell   (in_cell),
        .s1_valid  (s1_valid),
        .win       (win)
    );

    hgsd_diff u_diff (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .win      (win),
        .s3_valid (s3_valid),
        .pair     (pair)
    );

    hgsd_outq u_outq (
        .clk           (clk),
        .rst_n         (rst_n),
        .pair          (pair),
        .count         (q_count),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_reserve_bound: assert property (@(posedge clk) disable iff (!rst_n)
        reserved <= RSV_BITS'(OUTQ_DEPTH))
        else $error("queue reservation exceeds its depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        pair.valid |-> (q_count <= OUTQ_CNT_BITS'(OUTQ_DEPTH - 2)))
        else $error("result push without room in the queue");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (q_count == '0 && !s1_valid && !win.valid && !s3_valid && !pair.valid)
        |-> s_axis_tready)
        else $error("input held off while the block is empty");

    a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid)
        else $error("accepted transaction did not reach the line-buffer stage");

endmodule
`default_nettype wire

// ===== dv/tb_height_grid_local_step_detector_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_height_grid_local_step_detector_unit
// Self-checking testbench for the 3x3 height step detector.
// ----------------------------------------------------------------------------
// Grid cells are streamed into the block while a predictor keeps its own line
// buffers and window, works out the step results that each accepted cell
// should release, and checks every result transaction in order. A short
// directed part is followed by extreme frame shapes and then random frames
// under several mixes of source idling and sink back-pressure, with some
// register changes in the middle of a frame.
// ----------------------------------------------------------------------------
module tb_height_grid_local_step_detector_unit;

    import hgsd_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int SETTLE_WAIT  = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_CELLS  = 160;
    localparam int PRINT_LIMIT  = 200;

    class step_map_checker;
        cell_t       upper_row [MAX_WIDTH];
        cell_t       middle_row [MAX_WIDTH];
        cell_t       win [3][3];
        int unsigned col_pos;
        int unsigned row_pos;
        int unsigned width_reg;
        int unsigned rows_reg;
        int unsigned ceiling;
        int unsigned threshold;
        result_t     pending_steps [$];
        int unsigned result_count;
        int unsigned mismatch_count;

        function new();
            foreach (upper_row[i])
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            foreach (win[i, j])
                win[i][j] = '0;
            col_pos        = 0;
            row_pos        = 0;
            width_reg      = LINE_WIDTH_RESET;
            rows_reg       = FRAME_ROWS_RESET;
            ceiling        = MAX_DIFF_RESET;
            threshold      = MIN_DIFF_RESET;
            result_count   = 0;
            mismatch_count = 0;
        endfunction

        function void configure(input cfg_idx_t idx, input logic [15:0] value);
            case (idx)
                CFG_LINE_WIDTH: width_reg = value[10:0];
                CFG_FRAME_ROWS: rows_reg  = value[10:0];
                CFG_MAX_DIFF:   ceiling   = value;
                CFG_MIN_DIFF:   threshold = value;
                default: ;
            endcase
        endfunction

        function int unsigned effective_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > MAX_WIDTH)
                return MAX_WIDTH;
            return width_reg;
        endfunction

        function void queue_step(input result_t res);
            pending_steps.insert(pending_steps.size(), res);
        endfunction

        // cx selects the window column of the centre; the window is [column][row].
        function result_t grade(input int cx, input bit left_ok, input bit right_ok,
                                input bit top_ok, input bit bottom_ok, input bit final_one);
            result_t res;
            cell_t   ctr;
            cell_t   q;
            int      best;
            int      d;
            int      col;
            res  = '0;
            ctr  = win[cx][1];
            best = 0;
            if (ctr.p)
            begin
                for (int dc = -1; dc <= 1; dc++)
                begin
                    col = cx + dc;
                    if ((dc < 0 && !left_ok) || (dc > 0 && !right_ok) || col < 0 || col > 2)
                        continue;
                    for (int dr = 0; dr <= 2; dr++)
                    begin
                        q = win[col][dr];
                        if ((dr == 0 && !top_ok) || (dr == 2 && !bottom_ok) || !q.p)
                            continue;
                        d = int'(q.h) - int'(ctr.h);
                        if (d < 0)
                            d = -d;
                        if (d > best)
                            best = d;
                    end
                end
                if (best > int'(ceiling))
                    best = int'(ceiling);
                if (best > int'(threshold))
                begin
                    res.marked    = 1'b1;
                    res.step_size = 16'(best);
                end
            end
            res.center_present = ctr.p;
            res.apply          = ctr.rc;
            res.last           = final_one;
            return res;
        endfunction

        function void note_cell(input logic [15:0] h, input logic p, input logic rc);
            int unsigned w;
            int unsigned f;
            int unsigned c;
            int unsigned r;
            bit          at_end;
            bit          pad;
            cell_t       fresh;
            cell_t       up;
            cell_t       mid;
            w = effective_width();
            f = (rows_reg == 0) ? 1 : rows_reg;
            c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
            r = row_pos;
            at_end   = c >= w - 1;
            pad      = r >= f;
            fresh.h  = h;
            fresh.p  = p;
            fresh.rc = rc;
            up  = upper_row[c];
            mid = middle_row[c];
            for (int k = 0; k < 3; k++)
            begin
                win[0][k] = win[1][k];
                win[1][k] = win[2][k];
            end
            win[2][0]     = up;
            win[2][1]     = mid;
            win[2][2]     = fresh;
            upper_row[c]  = mid;
            middle_row[c] = fresh;
            if (r >= 1)
            begin
                if (c >= 1)
                    queue_step(grade(1, c >= 2, 1'b1, r >= 2, !pad, !at_end));
                if (at_end)
                    queue_step(grade(2, c >= 1, 1'b0, r >= 2, !pad, 1'b1));
            end
            if (at_end)
            begin
                col_pos = 0;
                row_pos = pad ? 0 : ((r + 1) & 'h7FF);
            end
            else
                col_pos = c + 1;
        endfunction

        task report_mismatch(input string what);
            mismatch_count++;
            if (mismatch_count <= PRINT_LIMIT)
                $display("mismatch: %s", what);
        endtask

        task check_step(input logic [15:0] step, input logic [2:0] flags, input logic last);
            result_t want;
            if (pending_steps.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing predicted, step_size %0d", step));
                return;
            end
            want = pending_steps.pop_front();
            if (step !== want.step_size)
                report_mismatch($sformatf("result %0d step_size %0d, predicted %0d",
                                          result_count, step, want.step_size));
            if (flags[0] !== want.marked)
                report_mismatch($sformatf("result %0d marked %b, predicted %b",
                                          result_count, flags[0], want.marked));
            if (flags[1] !== want.center_present)
                report_mismatch($sformatf("result %0d center_present %b, predicted %b",
                                          result_count, flags[1], want.center_present));
            if (flags[2] !== want.apply)
                report_mismatch($sformatf("result %0d apply %b, predicted %b",
                                          result_count, flags[2], want.apply));
            if (last !== want.last)
                report_mismatch($sformatf("result %0d last %b, predicted %b",
                                          result_count, last, want.last));
            result_count++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    logic [15:0] cfg_wdata;

    step_map_checker steps;
    int unsigned     cycle_count = 0;
    int unsigned     cells_sent = 0;
    int unsigned     send_idle_pct = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     recv_hold_cycles = 0;
    int unsigned     idle_mix [4] = '{0, 88, 0, 33};
    int unsigned     stall_mix [4] = '{0, 0, 88, 33};

    // Each entry is {recompute, present, height}.
    logic [17:0] directed_cells [24] = '{
        18'h38000, 18'h17FFF, 18'h20000, 18'h3FFFF,
        18'h10064, 18'h3FFFF, 18'h303E8, 18'h07FFF,
        18'h34E20, 18'h1B1E0, 18'h20000, 18'h30005,
        18'h38000, 18'h37FFF, 18'h10000,
        18'h30007, 18'h10007, 18'h30007,
        18'h30007, 18'h30007, 18'h08000,
        18'h38000, 18'h37FFF, 18'h30000
    };

    height_grid_local_step_detector_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                steps.check_step(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (recv_hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                recv_hold_cycles--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= 16'(value);
        @(posedge clk);
        steps.configure(idx, 16'(value));
        cfg_we <= 1'b0;
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned f,
                             input int unsigned hi, input int unsigned lo);
        write_reg(CFG_LINE_WIDTH, w);
        write_reg(CFG_FRAME_ROWS, f);
        write_reg(CFG_MAX_DIFF, hi);
        write_reg(CFG_MIN_DIFF, lo);
    endtask

    // Called from the test sequence, in step with the clock; leaves the block empty and quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (steps.pending_steps.size() > 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic send_cell(input logic [15:0] h, input logic p, input logic rc);
        int unsigned gap;
        gap = 0;
        while (gap < 64 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= h;
        s_axis_tuser  <= {rc, p};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        steps.note_cell(h, p, rc);
        cells_sent++;
    endtask

    task automatic random_cell(input int base);
        logic [15:0] h;
        if ($urandom_range(3) == 0)
            h = 16'($urandom_range(65535));
        else
            h = 16'(base + int'($urandom_range(1600)) - 800);
        send_cell(h, $urandom_range(99) < 80, 1'($urandom_range(1)));
    endtask

    task automatic retune_frame();
        int unsigned w;
        int unsigned f;
        int unsigned hi;
        int unsigned lo;
        case ($urandom_range(9))
            0:       w = 1;
            1:       w = 0;
            default: w = $urandom_range(2, 12);
        endcase
        case ($urandom_range(5))
            0:       f = 0;
            1:       f = 1;
            default: f = $urandom_range(2, 8);
        endcase
        case ($urandom_range(7))
            0:       hi = 0;
            1:       hi = 65535;
            2:       hi = $urandom_range(65535);
            default: hi = $urandom_range(200, 1500);
        endcase
        case ($urandom_range(7))
            0:       lo = 0;
            1:       lo = 65535;
            2:       lo = $urandom_range(65535);
            default: lo = $urandom_range(600);
        endcase
        set_frame(w, f, hi, lo);
    endtask

    // The line width only grows on the first row, so no unwritten buffer entry is used.
    task automatic retune_mid_frame();
        case ($urandom_range(3))
            0:
            begin
                if (steps.row_pos == 0)
                    write_reg(CFG_LINE_WIDTH, $urandom_range(12));
                else
                    write_reg(CFG_LINE_WIDTH, $urandom_range(steps.effective_width()));
            end
            1:       write_reg(CFG_FRAME_ROWS, $urandom_range(8));
            2:       write_reg(CFG_MAX_DIFF, $urandom_range(65535));
            default: write_reg(CFG_MIN_DIFF, $urandom_range(1500));
        endcase
    endtask

    task automatic run_frame(input int base, input bit allow_change);
        int unsigned sent;
        int unsigned change_at;
        sent      = 0;
        change_at = (allow_change && $urandom_range(3) == 0) ? $urandom_range(1, 40) : 0;
        do
        begin
            if (change_at != 0 && sent == change_at)
            begin
                settle();
                retune_mid_frame();
            end
            random_cell(base);
            sent++;
        end
        while (steps.col_pos != 0 || steps.row_pos != 0);
    endtask

    initial
    begin
        int unsigned phase_start;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_LINE_WIDTH;
        cfg_wdata     <= '0;
        steps = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        set_frame(4, 2, 1000, 100);
        for (int i = 0; i < 12; i++)
            send_cell(directed_cells[i][15:0], directed_cells[i][16], directed_cells[i][17]);
        settle();
        set_frame(3, 3, 65535, 0);
        for (int i = 12; i < 24; i++)
            send_cell(directed_cells[i][15:0], directed_cells[i][16], directed_cells[i][17]);

        settle();
        set_frame(0, 0, 65535, 65535);
        run_frame(0, 1'b0);
        settle();
        set_frame(1, 100, 1000, 100);
        run_frame(-2000, 1'b0);
        settle();
        recv_hold_cycles = 400;
        set_frame(200, 1, 300, 0);
        run_frame(12000, 1'b0);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = idle_mix[ph];
            recv_stall_pct = stall_mix[ph];
            phase_start    = cells_sent;
            while (cells_sent - phase_start < PHASE_CELLS)
            begin
                settle();
                retune_frame();
                run_frame(int'($urandom_range(65535)) - 32768, 1'b1);
            end
        end

        settle();
        if (steps.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
sv/hgsd_pkg.sv
sv/hgsd_ram.sv
sv/hgsd_window.sv
sv/hgsd_diff.sv
sv/hgsd_outq.sv
sv/height_grid_local_step_detector_unit.sv
dv/tb_height_grid_local_step_detector_unit.sv
